@@ sv/bptc_pkg.sv @@
`default_nettype none

package bptc_pkg;

  // Field widths
  localparam int unsigned CAL_W   = 16;
  localparam int unsigned RAW_W   = 24;
  localparam int unsigned TEMP_W  = 15;
  localparam int unsigned PRES_W  = 17;
  localparam int unsigned CIDX_W  = 3;

  // Start cycle to result strobe
  localparam int unsigned LATENCY = 10;

  // Compensation limits (0.01 degC / 0.01 mbar)
  localparam int TEMP_REF  = 2000;
  localparam int TEMP_VLOW = -1500;
  localparam int TEMP_MIN  = -4000;
  localparam int TEMP_MAX  = 8500;
  localparam int PRES_MIN  = 1000;
  localparam int PRES_MAX  = 120000;

  // Calibration register map
  typedef enum logic [CIDX_W-1:0] {
    CFG_C1_SENS    = 3'd0,
    CFG_C2_OFF     = 3'd1,
    CFG_C3_SENS_TC = 3'd2,
    CFG_C4_OFF_TC  = 3'd3,
    CFG_C5_TREF    = 3'd4,
    CFG_C6_TSENS   = 3'd5
  } cfg_idx_t;

endpackage

`default_nettype wire

@@ sv/baro_pressure_temp_compensation_unit.sv @@
// The result strobe is the last bit of the valid shift chain that a taken start enters.
// Throughput: one raw pair per cycle; busy stays low, the ten-stage pipeline never stalls.
// The result is shown for one cycle only; the receiver cannot hold it off.
// Calibration writes are always accepted (cfg_ready is always high); indices 6 and 7 are dropped.
// Reset (rst_n low, synchronous) clears the pipeline valid bits and all six
// calibration words to zero.
`default_nettype none

module baro_pressure_temp_compensation_unit (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  // sample channel
  input  wire logic                                 start,
  output logic                                      busy,
  input  wire logic [bptc_pkg::RAW_W-1:0]           in_raw_pressure,
  input  wire logic [bptc_pkg::RAW_W-1:0]           in_raw_temperature,
  // result channel
  output logic                                      out_valid,
  output logic signed [bptc_pkg::TEMP_W-1:0]        out_temperature_centi,
  output logic [bptc_pkg::PRES_W-1:0]               out_pressure_centi_mbar,
  output logic                                      out_temp_valid,
  output logic                                      out_saturated,
  // calibration write port
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [bptc_pkg::CIDX_W-1:0]          cfg_index,
  input  wire logic [bptc_pkg::CAL_W-1:0]           cfg_data
);

  localparam int unsigned NSTG = bptc_pkg::LATENCY;

  // ---------------------------------------------------------------------------
  // Calibration words
  // ---------------------------------------------------------------------------
  logic [bptc_pkg::CAL_W-1:0] c1_r, c2_r, c3_r, c4_r, c5_r, c6_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_r <= '0;
      c2_r <= '0;
      c3_r <= '0;
      c4_r <= '0;
      c5_r <= '0;
      c6_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (bptc_pkg::cfg_idx_t'(cfg_index))
        bptc_pkg::CFG_C1_SENS:    c1_r <= cfg_data;
        bptc_pkg::CFG_C2_OFF:     c2_r <= cfg_data;
        bptc_pkg::CFG_C3_SENS_TC: c3_r <= cfg_data;
        bptc_pkg::CFG_C4_OFF_TC:  c4_r <= cfg_data;
        bptc_pkg::CFG_C5_TREF:    c5_r <= cfg_data;
        bptc_pkg::CFG_C6_TSENS:   c6_r <= cfg_data;
        default: ;  // unmapped index, transfer is dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Valid bits, one per stage. Nothing ever stalls, so they just shift.
  // ---------------------------------------------------------------------------
  logic            take;
  logic [NSTG-1:0] vld_r, vld_nxt;

  assign busy    = 1'b0;
  assign take    = start && !busy;
  assign vld_nxt = {vld_r[NSTG-2:0], take};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: dT = D2 - C5*2^8, forced to zero for a zero raw temperature.
  // ---------------------------------------------------------------------------
  logic signed [24:0] dt_s1_r, dt_nxt;
  logic [23:0]        d1_s1_r;

  assign dt_nxt = (in_raw_temperature == '0) ? '0 :
                  $signed({1'b0, in_raw_temperature}) - $signed({1'b0, c5_r, 8'b0});

  // ---------------------------------------------------------------------------
  // Stage 2: the four products on dT.
  // ---------------------------------------------------------------------------
  logic signed [41:0] p6_nxt, p4_nxt, p3_nxt;
  logic signed [49:0] p2_nxt;
  logic signed [41:0] p6_s2_r, p4_s2_r, p3_s2_r;
  logic signed [49:0] p2_s2_r;
  logic [23:0]        d1_s2_r;
  logic               tv_s2_r, tv_nxt;

  assign p6_nxt = dt_s1_r * $signed({1'b0, c6_r});
  assign p4_nxt = dt_s1_r * $signed({1'b0, c4_r});
  assign p3_nxt = dt_s1_r * $signed({1'b0, c3_r});
  assign p2_nxt = dt_s1_r * dt_s1_r;
  assign tv_nxt = (dt_s1_r != '0);

  // ---------------------------------------------------------------------------
  // Stage 3: scale products; first-order OFF, SENS; T2.
  // ---------------------------------------------------------------------------
  logic signed [17:0] dd_nxt;      // TEMP - 2000 before T2
  logic signed [18:0] ee_nxt;      // TEMP + 1500 before T2
  logic signed [35:0] off_nxt;
  logic signed [34:0] sens_nxt;
  logic [17:0]        t2_nxt;

  assign dd_nxt   = p6_s2_r[40:23];
  assign ee_nxt   = 19'(dd_nxt) + 19'(bptc_pkg::TEMP_REF - bptc_pkg::TEMP_VLOW);
  assign off_nxt  = $signed({4'b0, c2_r, 16'b0}) + 36'($signed(p4_s2_r[41:7]));
  assign sens_nxt = $signed({4'b0, c1_r, 15'b0}) + 35'($signed(p3_s2_r[41:8]));
  assign t2_nxt   = p2_s2_r[48:31];

  logic signed [17:0] dd_s3_r;
  logic signed [18:0] ee_s3_r;
  logic signed [35:0] off_s3_r;
  logic signed [34:0] sens_s3_r;
  logic [17:0]        t2_s3_r;
  logic [23:0]        d1_s3_r;
  logic               tv_s3_r;

  // ---------------------------------------------------------------------------
  // Stage 4: squares for the second-order terms.
  // ---------------------------------------------------------------------------
  logic signed [35:0] dsq_full;
  logic signed [37:0] esq_full;
  logic signed [18:0] tpre_nxt;

  assign dsq_full = dd_s3_r * dd_s3_r;
  assign esq_full = ee_s3_r * ee_s3_r;
  assign tpre_nxt = 19'(dd_s3_r) + 19'(bptc_pkg::TEMP_REF);

  logic [34:0]        dsq_s4_r, esq_s4_r;
  logic               lo_s4_r, vlo_s4_r;
  logic signed [18:0] tpre_s4_r;
  logic signed [35:0] off_s4_r;
  logic signed [34:0] sens_s4_r;
  logic [17:0]        t2_s4_r;
  logic [23:0]        d1_s4_r;
  logic               tv_s4_r;

  // ---------------------------------------------------------------------------
  // Stage 5: OFF2, SENS2 and TEMP - T2 (only below 20.00 degC).
  // ---------------------------------------------------------------------------
  logic [37:0]        dsq5, esq7;
  logic [38:0]        esq11;
  logic [38:0]        off2_nxt, sens2_nxt;
  logic signed [19:0] temp_nxt;

  assign dsq5  = 38'({dsq_s4_r, 2'b0}) + 38'(dsq_s4_r);
  assign esq7  = 38'({esq_s4_r, 3'b0}) - 38'(esq_s4_r);
  assign esq11 = 39'({esq_s4_r, 3'b0}) + 39'({esq_s4_r, 1'b0}) + 39'(esq_s4_r);

  always_comb begin
    off2_nxt  = '0;
    sens2_nxt = '0;
    temp_nxt  = 20'(tpre_s4_r);
    if (lo_s4_r) begin
      off2_nxt  = 39'(dsq5 >> 1) + (vlo_s4_r ? 39'(esq7) : 39'd0);
      sens2_nxt = 39'(dsq5 >> 2) + (vlo_s4_r ? (esq11 >> 1) : 39'd0);
      temp_nxt  = 20'(tpre_s4_r) - $signed({2'b0, t2_s4_r});
    end
  end

  logic [38:0]        off2_s5_r, sens2_s5_r;
  logic signed [35:0] off_s5_r;
  logic signed [34:0] sens_s5_r;
  logic signed [19:0] temp_s5_r;
  logic [23:0]        d1_s5_r;
  logic               tv_s5_r;

  // ---------------------------------------------------------------------------
  // Stage 6: final OFF and SENS.
  // ---------------------------------------------------------------------------
  logic signed [39:0] offf_nxt, sensf_nxt;

  assign offf_nxt  = 40'(off_s5_r) - $signed({1'b0, off2_s5_r});
  assign sensf_nxt = 40'(sens_s5_r) - $signed({1'b0, sens2_s5_r});

  logic signed [39:0] offf_s6_r, sensf_s6_r;
  logic signed [19:0] temp_s6_r;
  logic [23:0]        d1_s6_r;
  logic               tv_s6_r;

  // ---------------------------------------------------------------------------
  // Stage 7: D1*SENS as two partial products (low 20 bits, signed high part).
  // ---------------------------------------------------------------------------
  logic [43:0]        pl_nxt;
  logic signed [44:0] ph_nxt;

  assign pl_nxt = d1_s6_r * sensf_s6_r[19:0];
  assign ph_nxt = $signed({1'b0, d1_s6_r}) * $signed(sensf_s6_r[39:20]);

  logic [43:0]        pl_s7_r;
  logic signed [44:0] ph_s7_r;
  logic signed [39:0] offf_s7_r;
  logic signed [19:0] temp_s7_r;
  logic               tv_s7_r;

  // ---------------------------------------------------------------------------
  // Stage 8: merge partials, divide by 2^21.
  // ---------------------------------------------------------------------------
  logic signed [64:0] prod_sum;
  logic signed [43:0] ps_nxt;

  assign prod_sum = $signed({ph_s7_r, 20'b0}) + $signed({21'b0, pl_s7_r});
  assign ps_nxt   = prod_sum[64:21];

  logic signed [43:0] ps_s8_r;
  logic signed [39:0] offf_s8_r;
  logic signed [19:0] temp_s8_r;
  logic               tv_s8_r;

  // ---------------------------------------------------------------------------
  // Stage 9: P = (D1*SENS/2^21 - OFF)/2^15.
  // ---------------------------------------------------------------------------
  logic signed [44:0] pdiff;
  logic signed [29:0] pres_nxt;

  assign pdiff    = 45'(ps_s8_r) - 45'(offf_s8_r);
  assign pres_nxt = pdiff[44:15];

  logic signed [29:0] pres_s9_r;
  logic signed [19:0] temp_s9_r;
  logic               tv_s9_r;

  // ---------------------------------------------------------------------------
  // Stage 10: clamp both results (a zero dT gives a zero temperature), flag any clamping.
  // ---------------------------------------------------------------------------
  logic signed [bptc_pkg::TEMP_W-1:0] tout_nxt;
  logic [bptc_pkg::PRES_W-1:0]        pout_nxt;
  logic                               tsat, psat;

  always_comb begin
    tsat = 1'b0;
    psat = 1'b0;
    priority if (!tv_s9_r) begin
      tout_nxt = '0;                 // zero dT: temperature not reported
    end else if (temp_s9_r < 20'(bptc_pkg::TEMP_MIN)) begin
      tout_nxt = bptc_pkg::TEMP_W'(bptc_pkg::TEMP_MIN);
      tsat     = 1'b1;
    end else if (temp_s9_r > 20'(bptc_pkg::TEMP_MAX)) begin
      tout_nxt = bptc_pkg::TEMP_W'(bptc_pkg::TEMP_MAX);
      tsat     = 1'b1;
    end else begin
      tout_nxt = temp_s9_r[bptc_pkg::TEMP_W-1:0];
    end
    priority if (pres_s9_r < 30'(bptc_pkg::PRES_MIN)) begin
      pout_nxt = bptc_pkg::PRES_W'(bptc_pkg::PRES_MIN);
      psat     = 1'b1;
    end else if (pres_s9_r > 30'(bptc_pkg::PRES_MAX)) begin
      pout_nxt = bptc_pkg::PRES_W'(bptc_pkg::PRES_MAX);
      psat     = 1'b1;
    end else begin
      pout_nxt = pres_s9_r[bptc_pkg::PRES_W-1:0];
    end
  end

  logic signed [bptc_pkg::TEMP_W-1:0] tout_r;
  logic [bptc_pkg::PRES_W-1:0]        pout_r;
  logic                               tvo_r, sat_r;

  // Datapath registers: no reset, qualified by vld_r.
  always_ff @(posedge clk) begin
    dt_s1_r    <= dt_nxt;
    d1_s1_r    <= in_raw_pressure;

    p6_s2_r    <= p6_nxt;
    p4_s2_r    <= p4_nxt;
    p3_s2_r    <= p3_nxt;
    p2_s2_r    <= p2_nxt;
    d1_s2_r    <= d1_s1_r;
    tv_s2_r    <= tv_nxt;

    dd_s3_r    <= dd_nxt;
    ee_s3_r    <= ee_nxt;
    off_s3_r   <= off_nxt;
    sens_s3_r  <= sens_nxt;
    t2_s3_r    <= t2_nxt;
    d1_s3_r    <= d1_s2_r;
    tv_s3_r    <= tv_s2_r;

    dsq_s4_r   <= dsq_full[34:0];
    esq_s4_r   <= esq_full[34:0];
    lo_s4_r    <= dd_s3_r[17];
    vlo_s4_r   <= ee_s3_r[18];
    tpre_s4_r  <= tpre_nxt;
    off_s4_r   <= off_s3_r;
    sens_s4_r  <= sens_s3_r;
    t2_s4_r    <= t2_s3_r;
    d1_s4_r    <= d1_s3_r;
    tv_s4_r    <= tv_s3_r;

    off2_s5_r  <= off2_nxt;
    sens2_s5_r <= sens2_nxt;
    off_s5_r   <= off_s4_r;
    sens_s5_r  <= sens_s4_r;
    temp_s5_r  <= temp_nxt;
    d1_s5_r    <= d1_s4_r;
    tv_s5_r    <= tv_s4_r;

    offf_s6_r  <= offf_nxt;
    sensf_s6_r <= sensf_nxt;
    temp_s6_r  <= temp_s5_r;
    d1_s6_r    <= d1_s5_r;
    tv_s6_r    <= tv_s5_r;

    pl_s7_r    <= pl_nxt;
    ph_s7_r    <= ph_nxt;
    offf_s7_r  <= offf_s6_r;
    temp_s7_r  <= temp_s6_r;
    tv_s7_r    <= tv_s6_r;

    ps_s8_r    <= ps_nxt;
    offf_s8_r  <= offf_s7_r;
    temp_s8_r  <= temp_s7_r;
    tv_s8_r    <= tv_s7_r;

    pres_s9_r  <= pres_nxt;
    temp_s9_r  <= temp_s8_r;
    tv_s9_r    <= tv_s8_r;

    tout_r     <= tout_nxt;
    pout_r     <= pout_nxt;
    tvo_r      <= tv_s9_r;
    sat_r      <= tsat || psat;
  end

  assign out_valid               = vld_r[NSTG-1];
  assign out_temperature_centi   = tout_r;
  assign out_pressure_centi_mbar = pout_r;
  assign out_temp_valid          = tvo_r;
  assign out_saturated           = sat_r;

endmodule

`default_nettype wire

@@ sv/bptc_checker.sv @@
`default_nettype none

module bptc_checker (
  input wire logic                                 clk,
  input wire logic                                 rst_n,
  input wire logic                                 start,
  input wire logic                                 busy,
  input wire logic                                 out_valid,
  input wire logic signed [bptc_pkg::TEMP_W-1:0]   out_temperature_centi,
  input wire logic [bptc_pkg::PRES_W-1:0]          out_pressure_centi_mbar,
  input wire logic                                 out_temp_valid
);

  // every result strobe traces back to a transfer a fixed latency earlier
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy && rst_n, bptc_pkg::LATENCY))
    else $error("result strobe without matching start");

  // pressure is always inside its clamp range
  a_pres: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_pressure_centi_mbar >= bptc_pkg::PRES_W'(bptc_pkg::PRES_MIN)) &&
                  (out_pressure_centi_mbar <= bptc_pkg::PRES_W'(bptc_pkg::PRES_MAX)))
    else $error("pressure out of range");

  // temperature is always inside its clamp range
  a_temp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_temperature_centi >= bptc_pkg::TEMP_W'(bptc_pkg::TEMP_MIN)) &&
                  (out_temperature_centi <= bptc_pkg::TEMP_W'(bptc_pkg::TEMP_MAX)))
    else $error("temperature out of range");

  // zero dT reports a zero temperature
  a_tzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_temp_valid) |-> (out_temperature_centi == '0))
    else $error("invalid temperature not reported as zero");

endmodule

bind baro_pressure_temp_compensation_unit bptc_checker u_bptc_checker (.*);

`default_nettype wire
